### hw/rtl/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

  // Fixed field widths of the item ports.
  localparam int SET_W   = 64;
  localparam int IDX_FW  = 6;
  // Width that holds any successor index and any instruction count.
  localparam int SUCC_CW = IDX_FW + 1;

  // One successor entry as it sits in the successor store.
  typedef struct packed {
    logic              b_valid;
    logic [IDX_FW-1:0] b_idx;
    logic              a_valid;
    logic [IDX_FW-1:0] a_idx;
  } succ_ent_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    LFS_IDLE,
    LFS_RD_SELF,
    LFS_RD_SUCC,
    LFS_UPDATE,
    LFS_EMIT
  } lfs_state_t;

endpackage

### hw/rtl/liveness_fixpoint_solver_unit.sv
`timescale 1ns / 1ps

// Iterative liveness solver over a small instruction graph.
// Input channel: an item is taken at a clock edge with start high and busy
// low. Each item loads one instruction (gen set, kill set, two successors
// with valid flags) into the next free slot; once INSTR_MAX
// slots are full further loads are dropped. An item with in_is_last set
// also starts the solve over all loaded instructions.
// Solve: repeated passes in index order until a pass changes nothing. Each
// instruction goes through three steps of read, successor read and write
// back on the live-in and live-out memories.
// Result channel: one item per loaded instruction in index order, one per
// cycle, each shown for a single cycle with out_valid high; the last carries
// out_last_result. The first result is registered out of the emission
// state that follows the final pass. The receiver cannot stall this channel.
// busy stays high from solve start until the last result is issued.
// Reset clears the load count and returns the block to idle; the live sets
// are cleared at the start of each solve through per-entry valid bits.
module liveness_fixpoint_solver_unit #(
  parameter int INSTR_MAX = 64,
  parameter int REG_COUNT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lfs_pkg::SET_W-1:0]  in_gen_set,
  input  logic [lfs_pkg::SET_W-1:0]  in_kill_set,
  input  logic [lfs_pkg::IDX_FW-1:0] in_succ_a,
  input  logic                       in_succ_a_valid,
  input  logic [lfs_pkg::IDX_FW-1:0] in_succ_b,
  input  logic                       in_succ_b_valid,
  input  logic                       in_is_last,
  output logic                       out_valid,
  output logic [lfs_pkg::IDX_FW-1:0] out_instr_index,
  output logic [lfs_pkg::SET_W-1:0]  out_live_in,
  output logic [lfs_pkg::SET_W-1:0]  out_live_out,
  output logic                       out_last_result
);
  import lfs_pkg::*;

  localparam int IDX_W = $clog2(INSTR_MAX);
  localparam int CNT_W = $clog2(INSTR_MAX + 1);
  localparam logic [SET_W-1:0] REG_MASK = {SET_W{1'b1}} >> (SET_W - REG_COUNT);

  // Stores.
  logic [SET_W-1:0] gen_mem  [INSTR_MAX];
  logic [SET_W-1:0] kill_mem [INSTR_MAX];
  succ_ent_t        succ_mem [INSTR_MAX];
  logic [SET_W-1:0] in_mem   [INSTR_MAX];
  logic [SET_W-1:0] out_mem  [INSTR_MAX];
  logic [INSTR_MAX-1:0] in_vld;
  logic [INSTR_MAX-1:0] out_vld;

  // Registered read data.
  logic [SET_W-1:0] gen_rd_r, kill_rd_r, in_a_rd_r, in_b_rd_r, out_rd_r;
  succ_ent_t        succ_rd_r;
  logic             in_va_r, in_vb_r, out_v_r;

  // Control state.
  lfs_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] ix_r, ix_nxt;
  logic [IDX_W-1:0] ex_r, ex_nxt;
  logic             chg_r, chg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;

  // Per-instruction working registers.
  logic [SET_W-1:0] in_old_r, in_old_nxt;
  logic             a_en_r, a_en_nxt;
  logic             b_en_r, b_en_nxt;

  // Access strobes and addresses.
  logic             load_we, upd_we, clr_vld, self_re;
  logic             in_a_re, in_b_re, out_re;
  logic [IDX_W-1:0] in_a_addr, in_b_addr, out_addr;
  logic             pass_chg;

  // Effective store values; an entry not written since solve start is zero.
  logic [SET_W-1:0] in_a_val, in_b_val, out_val;
  logic [SET_W-1:0] x_nin, x_nout;
  logic             x_changed;

  assign in_a_val = in_va_r ? in_a_rd_r : '0;
  assign in_b_val = in_vb_r ? in_b_rd_r : '0;
  assign out_val  = out_v_r ? out_rd_r  : '0;

  // Transfer function for the instruction under update.
  lfs_xfer u_xfer (
    .gen_set   (gen_rd_r),
    .kill_set  (kill_rd_r),
    .in_cur    (in_old_r),
    .out_cur   (out_val),
    .succ_a_in (in_a_val),
    .succ_a_en (a_en_r),
    .succ_b_in (in_b_val),
    .succ_b_en (b_en_r),
    .in_new    (x_nin),
    .out_new   (x_nout),
    .changed   (x_changed)
  );

  // Load stores: written on load, read for the instruction under update.
  always_ff @(posedge clk) begin
    if (load_we) begin
      gen_mem[cnt_r[IDX_W-1:0]]  <= in_gen_set & REG_MASK;
      kill_mem[cnt_r[IDX_W-1:0]] <= in_kill_set & REG_MASK;
      succ_mem[cnt_r[IDX_W-1:0]] <= '{b_valid: in_succ_b_valid, b_idx: in_succ_b,
                                      a_valid: in_succ_a_valid, a_idx: in_succ_a};
    end
    if (self_re) begin
      gen_rd_r  <= gen_mem[ix_r];
      kill_rd_r <= kill_mem[ix_r];
      succ_rd_r <= succ_mem[ix_r];
    end
  end

  // Live-in store with two read ports.
  always_ff @(posedge clk) begin
    if (upd_we) begin
      in_mem[ix_r] <= x_nin;
    end
    if (in_a_re) begin
      in_a_rd_r <= in_mem[in_a_addr];
    end
    if (in_b_re) begin
      in_b_rd_r <= in_mem[in_b_addr];
    end
  end

  // Live-out store.
  always_ff @(posedge clk) begin
    if (upd_we) begin
      out_mem[ix_r] <= x_nout;
    end
    if (out_re) begin
      out_rd_r <= out_mem[out_addr];
    end
  end

  // Written marks for the live sets, cleared together at solve start.
  always_ff @(posedge clk) begin
    if (clr_vld) begin
      in_vld  <= '0;
      out_vld <= '0;
    end else if (upd_we) begin
      in_vld[ix_r]  <= 1'b1;
      out_vld[ix_r] <= 1'b1;
    end
    if (in_a_re) begin
      in_va_r <= in_vld[in_a_addr];
    end
    if (in_b_re) begin
      in_vb_r <= in_vld[in_b_addr];
    end
    if (out_re) begin
      out_v_r <= out_vld[out_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LFS_IDLE;
      cnt_r       <= '0;
      ix_r        <= '0;
      ex_r        <= '0;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ix_r        <= ix_nxt;
      ex_r        <= ex_nxt;
      chg_r       <= chg_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk) begin
    out_idx_r <= out_idx_nxt;
    in_old_r  <= in_old_nxt;
    a_en_r    <= a_en_nxt;
    b_en_r    <= b_en_nxt;
  end

  // Sequencer: load, three-step update per instruction, then emission.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ix_nxt        = ix_r;
    ex_nxt        = ex_r;
    chg_nxt       = chg_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_idx_nxt   = out_idx_r;
    in_old_nxt    = in_old_r;
    a_en_nxt      = a_en_r;
    b_en_nxt      = b_en_r;
    load_we       = 1'b0;
    upd_we        = 1'b0;
    clr_vld       = 1'b0;
    self_re       = 1'b0;
    in_a_re       = 1'b0;
    in_b_re       = 1'b0;
    out_re        = 1'b0;
    in_a_addr     = ix_r;
    in_b_addr     = ix_r;
    out_addr      = ix_r;
    pass_chg      = chg_r | x_changed;
    unique case (state_r)
      LFS_IDLE: begin
        if (start) begin
          if (cnt_r < CNT_W'(INSTR_MAX)) begin
            load_we = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_is_last) begin
            clr_vld   = 1'b1;
            ix_nxt    = '0;
            chg_nxt   = 1'b0;
            state_nxt = LFS_RD_SELF;
          end
        end
      end
      LFS_RD_SELF: begin
        self_re   = 1'b1;
        in_a_re   = 1'b1;
        out_re    = 1'b1;
        state_nxt = LFS_RD_SUCC;
      end
      LFS_RD_SUCC: begin
        // Keep the old live-in, then fetch the successor live-in sets.
        in_old_nxt = in_a_val;
        in_a_re    = 1'b1;
        in_b_re    = 1'b1;
        in_a_addr  = succ_rd_r.a_idx[IDX_W-1:0];
        in_b_addr  = succ_rd_r.b_idx[IDX_W-1:0];
        a_en_nxt   = succ_rd_r.a_valid &&
                     (SUCC_CW'(succ_rd_r.a_idx) < SUCC_CW'(cnt_r));
        b_en_nxt   = succ_rd_r.b_valid &&
                     (SUCC_CW'(succ_rd_r.b_idx) < SUCC_CW'(cnt_r));
        state_nxt  = LFS_UPDATE;
      end
      LFS_UPDATE: begin
        upd_we = 1'b1;
        if (CNT_W'(ix_r) + CNT_W'(1) == cnt_r) begin
          if (pass_chg) begin
            ix_nxt    = '0;
            chg_nxt   = 1'b0;
            state_nxt = LFS_RD_SELF;
          end else begin
            ex_nxt    = '0;
            state_nxt = LFS_EMIT;
          end
        end else begin
          ix_nxt    = ix_r + IDX_W'(1);
          chg_nxt   = pass_chg;
          state_nxt = LFS_RD_SELF;
        end
      end
      LFS_EMIT: begin
        in_a_re       = 1'b1;
        out_re        = 1'b1;
        in_a_addr     = ex_r;
        out_addr      = ex_r;
        out_valid_nxt = 1'b1;
        out_idx_nxt   = ex_r;
        out_last_nxt  = (CNT_W'(ex_r) + CNT_W'(1) == cnt_r);
        if (CNT_W'(ex_r) + CNT_W'(1) == cnt_r) begin
          cnt_nxt   = '0;
          state_nxt = LFS_IDLE;
        end else begin
          ex_nxt = ex_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = LFS_IDLE;
      end
    endcase
  end

  // Ports.
  assign busy            = (state_r != LFS_IDLE);
  assign out_valid       = out_valid_r;
  assign out_instr_index = IDX_FW'(out_idx_r);
  assign out_live_in     = in_a_val;
  assign out_live_out    = out_val;
  assign out_last_result = out_last_r;

  // The load count never exceeds the store depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(INSTR_MAX))
    else $error("load count beyond store depth");

  // Results only come out of an emission read issued while busy.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == LFS_EMIT))
    else $error("result item without emission read");

  // The last mark only rides on a result.
  a_last_marks_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> out_valid)
    else $error("last mark without result item");

  // A quiet pass that finished goes straight to emission.
  a_quiet_pass_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == LFS_UPDATE && !pass_chg && CNT_W'(ix_r) + CNT_W'(1) == cnt_r)
    |=> (state_r == LFS_EMIT && ex_r == '0))
    else $error("converged pass did not start emission");

  // The final result returns the block to idle with the store emptied.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> (state_r == LFS_IDLE && cnt_r == '0))
    else $error("block not idle after final result item");

endmodule

### hw/rtl/lfs_xfer.sv
`timescale 1ns / 1ps

module lfs_xfer (
  input  logic [lfs_pkg::SET_W-1:0] gen_set,
  input  logic [lfs_pkg::SET_W-1:0] kill_set,
  input  logic [lfs_pkg::SET_W-1:0] in_cur,
  input  logic [lfs_pkg::SET_W-1:0] out_cur,
  input  logic [lfs_pkg::SET_W-1:0] succ_a_in,
  input  logic                      succ_a_en,
  input  logic [lfs_pkg::SET_W-1:0] succ_b_in,
  input  logic                      succ_b_en,
  output logic [lfs_pkg::SET_W-1:0] in_new,
  output logic [lfs_pkg::SET_W-1:0] out_new,
  output logic                      changed
);
  import lfs_pkg::*;

  logic [SET_W-1:0] a_part;
  logic [SET_W-1:0] b_part;

  // Live-in follows from the current live-out of the same instruction.
  assign in_new = gen_set | (out_cur & ~kill_set);

  // Live-out is the union of the live-in sets of the usable successors.
  assign a_part  = succ_a_en ? succ_a_in : '0;
  assign b_part  = succ_b_en ? succ_b_in : '0;
  assign out_new = a_part | b_part;

  // Any difference forces another pass.
  assign changed = (in_new != in_cur) || (out_new != out_cur);

endmodule

### verif/liveness_fixpoint_solver_unit_tb.sv
`timescale 1ns / 1ps

module liveness_fixpoint_solver_unit_tb;
  import lfs_pkg::*;

  localparam int INSTR_MAX    = 64;
  localparam int REGS         = 64;
  localparam int SLOT_W       = $clog2(INSTR_MAX);
  localparam int RANDOM_ITEMS = 230;
  localparam int DRAIN_CYCLES = 16;
  // A full 64-entry chain needs about 130 passes; the run holds two such
  // solves plus small ones, so this leaves a wide margin.
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic [SET_W-1:0] REG_MASK =
    (REGS >= 64) ? {SET_W{1'b1}} : ((64'd1 << REGS) - 64'd1);
  localparam logic [SET_W-1:0] ONES = {SET_W{1'b1}};

  // One instruction as it is handed to the block.
  typedef struct packed {
    logic [SET_W-1:0]  gen;
    logic [SET_W-1:0]  kill;
    logic [IDX_FW-1:0] sa;
    logic              sav;
    logic [IDX_FW-1:0] sb;
    logic              sbv;
    logic              is_last;
  } instr_item_t;

  // One live-in/live-out report for an instruction.
  typedef struct packed {
    logic [IDX_FW-1:0] idx;
    logic [SET_W-1:0]  lin;
    logic [SET_W-1:0]  lout;
    logic              last_flag;
  } live_result_t;

  // A directed row; typed rows carry their single result written out.
  typedef struct packed {
    instr_item_t      it;
    logic             typed;
    logic [SET_W-1:0] ein;
    logic [SET_W-1:0] eout;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [SET_W-1:0]  in_gen_set = '0;
  logic [SET_W-1:0]  in_kill_set = '0;
  logic [IDX_FW-1:0] in_succ_a = '0;
  logic              in_succ_a_valid = 1'b0;
  logic [IDX_FW-1:0] in_succ_b = '0;
  logic              in_succ_b_valid = 1'b0;
  logic              in_is_last = 1'b0;
  logic              busy;
  logic              out_valid;
  logic [IDX_FW-1:0] out_instr_index;
  logic [SET_W-1:0]  out_live_in;
  logic [SET_W-1:0]  out_live_out;
  logic              out_last_result;

  liveness_fixpoint_solver_unit #(
    .INSTR_MAX(INSTR_MAX),
    .REG_COUNT(REGS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_gen_set(in_gen_set),
    .in_kill_set(in_kill_set),
    .in_succ_a(in_succ_a),
    .in_succ_a_valid(in_succ_a_valid),
    .in_succ_b(in_succ_b),
    .in_succ_b_valid(in_succ_b_valid),
    .in_is_last(in_is_last),
    .out_valid(out_valid),
    .out_instr_index(out_instr_index),
    .out_live_in(out_live_in),
    .out_live_out(out_live_out),
    .out_last_result(out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the instruction stores and the live sets.
  logic [SET_W-1:0] shadow_gen [INSTR_MAX];
  logic [SET_W-1:0] shadow_kill [INSTR_MAX];
  succ_ent_t        shadow_succ [INSTR_MAX];
  logic [SET_W-1:0] sol_in [INSTR_MAX];
  logic [SET_W-1:0] sol_out [INSTR_MAX];
  int unsigned      shadow_count = 0;

  live_result_t pending_live [$];
  dir_row_t     dir_tab [$];
  live_result_t want;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  // Iterate the liveness equations in index order until a pass is quiet.
  function automatic void solve_liveness(input int unsigned n);
    int unsigned      i;
    logic [SET_W-1:0] nin;
    logic [SET_W-1:0] nout;
    bit               changed;
    for (i = 0; i < INSTR_MAX; i++) begin
      sol_in[SLOT_W'(i)] = '0;
      sol_out[SLOT_W'(i)] = '0;
    end
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (i = 0; i < n; i++) begin
        nin = shadow_gen[SLOT_W'(i)] | (sol_out[SLOT_W'(i)] & ~shadow_kill[SLOT_W'(i)]);
        nout = '0;
        // A successor at or beyond the loaded count contributes nothing.
        if (shadow_succ[SLOT_W'(i)].a_valid && shadow_succ[SLOT_W'(i)].a_idx < n)
          nout |= sol_in[shadow_succ[SLOT_W'(i)].a_idx];
        if (shadow_succ[SLOT_W'(i)].b_valid && shadow_succ[SLOT_W'(i)].b_idx < n)
          nout |= sol_in[shadow_succ[SLOT_W'(i)].b_idx];
        if (nin != sol_in[SLOT_W'(i)]) begin
          changed = 1'b1;
          sol_in[SLOT_W'(i)] = nin;
        end
        if (nout != sol_out[SLOT_W'(i)]) begin
          changed = 1'b1;
          sol_out[SLOT_W'(i)] = nout;
        end
      end
    end
  endfunction

  // Load one item into the shadow stores; returns the number of results.
  function automatic int unsigned apply_item(input instr_item_t it);
    int unsigned n;
    // Once the store is full, loads are dropped but is_last still solves.
    if (shadow_count < INSTR_MAX) begin
      shadow_gen[SLOT_W'(shadow_count)] = it.gen & REG_MASK;
      shadow_kill[SLOT_W'(shadow_count)] = it.kill & REG_MASK;
      shadow_succ[SLOT_W'(shadow_count)].a_idx = it.sa;
      shadow_succ[SLOT_W'(shadow_count)].a_valid = it.sav;
      shadow_succ[SLOT_W'(shadow_count)].b_idx = it.sb;
      shadow_succ[SLOT_W'(shadow_count)].b_valid = it.sbv;
      shadow_count++;
    end
    if (!it.is_last) return 0;
    n = shadow_count;
    solve_liveness(n);
    shadow_count = 0;
    return n;
  endfunction

  function automatic live_result_t make_result(input int unsigned idx,
                                               input logic [SET_W-1:0] lin,
                                               input logic [SET_W-1:0] lout,
                                               input logic last_flag);
    live_result_t r;
    r.idx = idx[IDX_FW-1:0];
    r.lin = lin;
    r.lout = lout;
    r.last_flag = last_flag;
    return r;
  endfunction

  // Append one expected result behind the ones already waiting.
  function automatic void expect_live(input live_result_t r);
    pending_live.insert(pending_live.size(), r);
  endfunction

  function automatic void push_solution(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++)
      expect_live(make_result(i, sol_in[SLOT_W'(i)], sol_out[SLOT_W'(i)], i + 1 == n));
  endfunction

  function automatic void add_row(input logic [SET_W-1:0] gen,
                                  input logic [SET_W-1:0] kill,
                                  input int sa, input bit sav,
                                  input int sb, input bit sbv,
                                  input bit is_last, input bit typed,
                                  input logic [SET_W-1:0] ein,
                                  input logic [SET_W-1:0] eout);
    dir_row_t row;
    row.it.gen = gen;
    row.it.kill = kill;
    row.it.sa = sa[IDX_FW-1:0];
    row.it.sav = sav;
    row.it.sb = sb[IDX_FW-1:0];
    row.it.sbv = sbv;
    row.it.is_last = is_last;
    row.typed = typed;
    row.ein = ein;
    row.eout = eout;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic logic [SET_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input instr_item_t it, output int unsigned n);
    start <= 1'b1;
    in_gen_set <= it.gen;
    in_kill_set <= it.kill;
    in_succ_a <= it.sa;
    in_succ_a_valid <= it.sav;
    in_succ_b <= it.sb;
    in_succ_b_valid <= it.sbv;
    in_is_last <= it.is_last;
    @(posedge clk);
    while (busy) @(posedge clk);
    n = apply_item(it);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_live.size() != 0) @(posedge clk);
  endtask

  // Compare every strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_live.size() == 0) begin
        $error("unexpected result for instruction %0d", out_instr_index);
        mismatch_count++;
      end else begin
        want = pending_live.pop_front();
        if (out_instr_index !== want.idx) begin
          $error("instr_index: expected %0d, got %0d", want.idx, out_instr_index);
          mismatch_count++;
        end
        if (out_live_in !== want.lin) begin
          $error("live_in: expected %h, got %h", want.lin, out_live_in);
          mismatch_count++;
        end
        if (out_live_out !== want.lout) begin
          $error("live_out: expected %h, got %h", want.lout, out_live_out);
          mismatch_count++;
        end
        if (out_last_result !== want.last_flag) begin
          $error("last_result: expected %0b, got %0b", want.last_flag, out_last_result);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int          k;
    int          seq;
    int          len;
    int          pos;
    int          sent;
    int          span;
    bit          quiet;
    bit          cfg_shape;
    dir_row_t    row;
    instr_item_t it;

    // Single-instruction solves whose results are obvious.
    add_row(ONES, '0, 0, 0, 0, 0, 1, 1, ONES, '0);
    add_row('0, ONES, 0, 1, 63, 1, 1, 1, '0, '0);
    add_row(64'h0F, ONES, 0, 1, 0, 1, 1, 1, 64'h0F, 64'h0F);
    add_row(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 63, 1, 1, 1, 1, 1,
            64'hA5A5_A5A5_A5A5_A5A5, '0);
    add_row(64'h8000_0000_0000_0001, '0, 63, 0, 63, 0, 1, 1,
            64'h8000_0000_0000_0001, '0);
    add_row(ONES, ONES, 0, 1, 0, 0, 1, 1, ONES, ONES);
    // Straight-line pair.
    add_row(64'h3, 64'h4, 1, 1, 0, 0, 0, 0, '0, '0);
    add_row(64'h4, 64'h1, 0, 0, 0, 0, 1, 0, '0, '0);
    // Loop with a back edge to the head.
    add_row(64'h10, 64'h01, 1, 1, 0, 0, 0, 0, '0, '0);
    add_row(64'h02, 64'h10, 2, 1, 0, 1, 0, 0, '0, '0);
    add_row(64'h00, 64'h04, 3, 1, 1, 1, 0, 0, '0, '0);
    add_row(64'h100, 64'h0, 0, 0, 0, 0, 1, 0, '0, '0);
    // Successors beyond the loaded count.
    add_row(ONES, ONES, 2, 1, 40, 1, 0, 0, '0, '0);
    add_row('0, ONES, 0, 1, 2, 1, 0, 0, '0, '0);
    add_row(64'hDEAD_BEEF_0123_4567, 64'h00FF_00FF_00FF_00FF, 63, 1, 0, 1, 1, 0,
            '0, '0);
    // Diamond.
    add_row(64'h1, 64'h0, 1, 1, 2, 1, 0, 0, '0, '0);
    add_row(64'h2, 64'h1, 3, 1, 0, 0, 0, 0, '0, '0);
    add_row(64'h4, 64'h2, 3, 1, 0, 0, 0, 0, '0, '0);
    add_row(64'h0, 64'h4, 0, 0, 63, 0, 1, 0, '0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    for (k = 0; k < dir_tab.size(); k++) begin
      row = dir_tab[k];
      send_item(row.it, n);
      if (n != 0) begin
        if (row.typed)
          expect_live(make_result(0, row.ein, row.eout, 1'b1));
        else
          push_solution(n);
      end
    end
    pause_until_drained();

    // Random part: mostly branchy straight-line code, some noise graphs.
    // One sequence overruns the store and one fills it exactly.
    sent = 0;
    seq = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seq == 3) len = 66;
      else if (seq == 8) len = 64;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 20);
      else len = $urandom_range(1, 8);
      span = (len > INSTR_MAX) ? INSTR_MAX : len;
      cfg_shape = ($urandom_range(0, 99) < 75);
      quiet = (seq >= 10 && seq < 18);
      if (seq % 6 == 5 && !quiet) pause_until_drained();
      for (pos = 0; pos < len; pos++) begin
        if (!quiet && $urandom_range(0, 99) < 3) hold_off($urandom_range(1, 5));
        it.gen = $urandom_range(0, 1) ? rand64() : (rand64() & rand64() & rand64());
        it.kill = $urandom_range(0, 1) ? rand64() : (rand64() & rand64() & rand64());
        it.sa = IDX_FW'($urandom_range(0, 63));
        it.sav = 1'($urandom_range(0, 1));
        it.sb = IDX_FW'($urandom_range(0, 63));
        it.sbv = 1'($urandom_range(0, 1));
        if (cfg_shape) begin
          // Fall through to the next instruction, branch anywhere loaded.
          it.sav = (pos + 1 < len);
          if (it.sav) it.sa = IDX_FW'(pos + 1);
          it.sbv = ($urandom_range(0, 99) < 40);
          if (it.sbv) it.sb = IDX_FW'($urandom_range(0, span - 1));
        end
        it.is_last = (pos == len - 1);
        send_item(it, n);
        sent++;
        if (n != 0) push_solution(n);
      end
      seq++;
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
